// ===== sv/utf8_stream_validator_unit_assert.svh =====
// Assertion macros used by the UTF-8 stream validator top level.
`ifndef UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UTF8SV_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define UTF8SV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/utf8sv_pkg.sv =====
// Package: decoder state type, byte class masks and overlong limits.
`timescale 1ns / 1ps

package utf8sv_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned CountW  = 3;
    localparam int unsigned CodeW   = 31;
    localparam int unsigned TdataW  = 8;

    // Lead and continuation byte class masks / patterns
    localparam logic [ByteW-1:0] MaskTop1  = 8'h80;
    localparam logic [ByteW-1:0] MaskTop2  = 8'hc0;
    localparam logic [ByteW-1:0] MaskTop3  = 8'he0;
    localparam logic [ByteW-1:0] MaskTop4  = 8'hf0;
    localparam logic [ByteW-1:0] MaskTop5  = 8'hf8;
    localparam logic [ByteW-1:0] MaskTop6  = 8'hfc;
    localparam logic [ByteW-1:0] MaskTop7  = 8'hfe;
    localparam logic [ByteW-1:0] PatCont   = 8'h80;
    localparam logic [ByteW-1:0] PatLead2  = 8'hc0;
    localparam logic [ByteW-1:0] PatLead3  = 8'he0;
    localparam logic [ByteW-1:0] PatLead4  = 8'hf0;
    localparam logic [ByteW-1:0] PatLead5  = 8'hf8;
    localparam logic [ByteW-1:0] PatLead6  = 8'hfc;
    localparam logic [5:0]       ContPayloadMask = 6'h3f;

    localparam logic [CountW-1:0] MaxCont = 3'd5;

    typedef struct packed {
        logic [CountW-1:0] bytes_left;
        logic [CountW-1:0] seq_length;
        logic [CodeW-1:0]  code_point;
        logic              failed;
    } dec_state_t;

    // Smallest legal code point for a sequence with n continuation bytes
    function automatic logic [CodeW-1:0] min_code(input logic [CountW-1:0] n);
        logic [CodeW-1:0] r;
        unique case (n)
            3'd1:    r = 31'h0000080;
            3'd2:    r = 31'h0000800;
            3'd3:    r = 31'h0010000;
            3'd4:    r = 31'h0200000;
            3'd5:    r = 31'h4000000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/utf8_stream_validator_unit.sv =====
// Top level: UTF-8 (six-byte form) stream validator with stream handshakes.
//
// Input channel s_*: one byte of the string per request in s_tdata[7:0],
// s_tlast marks the last byte of a string. Result channel m_*: one result
// per input byte; m_tdata[0] is the running verdict (1 = no violation so
// far in this string, this byte included), m_tlast echoes s_tlast, and
// the verdict is final on the request where m_tlast is 1.
// A taken byte is held in the input stage, then passes the byte decoder
// into the decoder state plus result register that drives m_* (two
// registers). Throughput: one byte per cycle unless m_tready stalls it, set
// by the single pass through the byte decoder between the two registers.
// Reset (aresetn low, synchronous): both stages empty, decoder state and
// the sticky failure flag cleared, as at the start of a new string.
// When the receiver holds m_tready low the result register holds, the
// input stage fills, and s_tready falls; no request is lost or repeated.
`timescale 1ns / 1ps

module utf8_stream_validator_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [utf8sv_pkg::TdataW-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,   // last_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [utf8sv_pkg::TdataW-1:0]    m_tdata,   // [0] string_ok, [7:1] zero
    output logic                             m_tlast    // is_final
);
    import utf8sv_pkg::*;

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_last_reg;
    dec_state_t       state_reg;
    dec_state_t       state_next;
    logic             step_ok;
    logic             out_valid_reg;
    logic             out_ok_reg;
    logic             out_last_reg;
    logic             advance;
    logic             s_take;

    assign advance  = ~out_valid_reg | m_tready;
    assign s_tready = ~in_valid_reg | advance;
    assign s_take   = s_tvalid & s_tready;

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_tdata[ByteW-1:0];
            in_last_reg <= s_tlast;
        end
    end

    // Byte decoder
    utf8sv_step u_step (
        .cur_state  (state_reg),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .next_state (state_next),
        .string_ok  (step_ok)
    );

    // Decoder state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_ok_reg   <= step_ok;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TdataW-1){1'b0}}, out_ok_reg};
    assign m_tlast  = out_last_reg;

    `include "utf8_stream_validator_unit_assert.svh"

    `UTF8SV_ASSERT_NEXT(a_clear_after_last, aclk, aresetn,
        advance && in_valid_reg && in_last_reg, state_reg == '0,
        "decoder state not cleared after last byte")
    `UTF8SV_ASSERT_NEXT(a_failed_sticky, aclk, aresetn,
        advance && in_valid_reg && state_reg.failed, !out_ok_reg,
        "verdict recovered inside a failed string")
    `UTF8SV_ASSERT_NOW(a_left_range, aclk, aresetn,
        1'b1, state_reg.bytes_left <= MaxCont,
        "continuation count out of range")
    `UTF8SV_ASSERT_NOW(a_left_le_len, aclk, aresetn,
        state_reg.bytes_left != '0,
        state_reg.seq_length != '0 && state_reg.bytes_left <= state_reg.seq_length,
        "open sequence count exceeds its length")

endmodule

// ===== sv/utf8sv_step.sv =====
// Combinational next-state logic: one byte through the UTF-8 decoder state.
`timescale 1ns / 1ps

module utf8sv_step (
    input  utf8sv_pkg::dec_state_t          cur_state,
    input  logic [utf8sv_pkg::ByteW-1:0]    data_byte,
    input  logic                            last_byte,
    output utf8sv_pkg::dec_state_t          next_state,
    output logic                            string_ok
);
    import utf8sv_pkg::*;

    dec_state_t       upd;
    logic [CodeW-1:0] shifted;
    logic [CountW-1:0] left_dec;

    assign shifted  = {cur_state.code_point[CodeW-7:0], data_byte[5:0] & ContPayloadMask};
    assign left_dec = cur_state.bytes_left - 3'd1;

    // Byte update; skipped entirely once the string has failed
    always_comb begin
        upd = cur_state;
        if (cur_state.failed) begin
            upd = cur_state;
        end else if (cur_state.bytes_left == '0) begin
            // expecting a lead byte
            priority if ((data_byte & MaskTop1) == '0) begin
                upd = cur_state;
            end else if ((data_byte & MaskTop3) == PatLead2) begin
                upd.seq_length = 3'd1;
                upd.bytes_left = 3'd1;
                upd.code_point = {26'd0, data_byte[4:0]};
            end else if ((data_byte & MaskTop4) == PatLead3) begin
                upd.seq_length = 3'd2;
                upd.bytes_left = 3'd2;
                upd.code_point = {27'd0, data_byte[3:0]};
            end else if ((data_byte & MaskTop5) == PatLead4) begin
                upd.seq_length = 3'd3;
                upd.bytes_left = 3'd3;
                upd.code_point = {28'd0, data_byte[2:0]};
            end else if ((data_byte & MaskTop6) == PatLead5) begin
                upd.seq_length = 3'd4;
                upd.bytes_left = 3'd4;
                upd.code_point = {29'd0, data_byte[1:0]};
            end else if ((data_byte & MaskTop7) == PatLead6) begin
                upd.seq_length = 3'd5;
                upd.bytes_left = 3'd5;
                upd.code_point = {30'd0, data_byte[0]};
            end else begin
                upd.failed = 1'b1;
            end
        end else if ((data_byte & MaskTop2) != PatCont) begin
            // non-continuation inside a sequence
            upd.failed = 1'b1;
        end else begin
            upd.code_point = shifted;
            upd.bytes_left = left_dec;
            // overlong check on completion
            if (left_dec == '0 && shifted < min_code(cur_state.seq_length)) begin
                upd.failed = 1'b1;
            end
        end
    end

    assign string_ok  = ~upd.failed;
    // Clear all state after the last byte of a string
    assign next_state = last_byte ? dec_state_t'('0) : upd;

endmodule
